[design/led_bar_pattern_sequencer_macros.svh]
// Assertion helpers shared by the sequencer RTL.
`ifndef LED_BAR_PATTERN_SEQUENCER_MACROS_SVH
`define LED_BAR_PATTERN_SEQUENCER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define LBPS_ASSERT_SAME(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define LBPS_ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

[design/lbps_pkg.sv]
package lbps_pkg;

	localparam int WORD_BITS = 16;

	// Operation codes
	localparam logic [2:0] OP_SET_BARS = 3'd0;
	localparam logic [2:0] OP_CLEAR    = 3'd1;
	localparam logic [2:0] OP_SET_ALL  = 3'd2;
	localparam logic [2:0] OP_STOP     = 3'd3;
	localparam logic [2:0] OP_PAUSE    = 3'd4;
	localparam logic [2:0] OP_RESUME   = 3'd5;
	localparam logic [2:0] OP_TICK     = 3'd6;

	// Pattern numbers
	localparam logic [3:0] PAT_NONE      = 4'd0;
	localparam logic [3:0] PAT_INCREMENT = 4'd1;
	localparam logic [3:0] PAT_DECREMENT = 4'd2;
	localparam logic [3:0] PAT_CHASE     = 4'd3;
	localparam logic [3:0] PAT_GROW      = 4'd4;
	localparam logic [3:0] PAT_SHRINK    = 4'd5;
	localparam logic [3:0] PAT_HEART     = 4'd6;
	localparam logic [3:0] PAT_BOUNCE    = 4'd7;
	localparam logic [3:0] PAT_RANDOM    = 4'd8;
	localparam logic [3:0] PAT_WAVE      = 4'd9;
	localparam logic [3:0] PAT_ALT       = 4'd10;

	// Register indexes
	localparam logic [1:0] REG_SPEED   = 2'd0;
	localparam logic [1:0] REG_PINS    = 2'd1;
	localparam logic [1:0] REG_CHIPS   = 2'd2;
	localparam logic [1:0] REG_REPEATS = 2'd3;

	// Sources for the chip word writer
	localparam logic [1:0] SRC_VEC  = 2'd0;
	localparam logic [1:0] SRC_PIN  = 2'd1;
	localparam logic [1:0] SRC_ONES = 2'd2;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam logic [15:0] ALT_ODD   = 16'h5555;
	localparam logic [15:0] ALT_EVEN  = 16'hAAAA;
	localparam logic [15:0] ALL_ONES  = 16'hFFFF;
	localparam logic [63:0] RECIP10   = 64'h00000000CCCCCCCD;

	typedef struct packed {
		logic [3:0]  pattern;
		logic [7:0]  step;
		logic [15:0] lfsr;
	} pat_req_t;

	function automatic logic [15:0] low_mask(input logic [4:0] n);
		logic [15:0] m;
		if (n >= 5'd16) begin
			m = ALL_ONES;
		end else begin
			m = (16'd1 << n[3:0]) - 16'd1;
		end
		return m;
	endfunction

endpackage

[design/lbps_ram.sv]
module lbps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/lbps_pattern.sv]
module lbps_pattern import lbps_pkg::*; #(
	parameter int TW = 8
) (
	input  pat_req_t        req,
	input  logic [TW-1:0]   total,
	input  logic [TW-1:0]   step_mod,
	output logic [15:0]     st,
	output logic [15:0]     lfsr_next
);

	localparam int SW = ((TW > 8) ? TW : 8) + 2;

	logic signed [SW-1:0] s, tot, half, lim, down, one_s, zero_s;
	logic [15:0] prod3;
	logic [7:0]  q3;
	logic [1:0]  sm3;

	// Advance the Galois LFSR by one step
	always_comb begin
		lfsr_next = req.lfsr >> 1;
		if (req.lfsr[0]) begin
			lfsr_next = (req.lfsr >> 1) ^ LFSR_TAPS;
		end
	end

	// Step modulo three by reciprocal multiply
	always_comb begin
		prod3 = 16'(req.step) * 16'd171;
		q3 = {1'b0, prod3[15:9]};
		sm3 = 2'(req.step - (q3 + {q3[6:0], 1'b0}));
	end

	// Build one 16-bit pattern word, bit by bit
	always_comb begin
		logic signed [SW-1:0] jj, k;
		logic [1:0] jm3;
		logic b;
		one_s = signed'(SW'(1));
		zero_s = signed'(SW'(0));
		s = signed'(SW'(req.step));
		tot = signed'(SW'(total));
		half = signed'(SW'(total >> 1));
		lim = (s < half) ? (s + one_s) : (tot - s + half);
		down = tot - one_s - s;
		st = 16'd0;
		jm3 = 2'd0;
		for (int j = 0; j < 16; j++) begin
			jj = signed'(SW'(j));
			k = tot - one_s - jj;
			case (req.pattern)
				PAT_INCREMENT, PAT_BOUNCE: b = (jj == s);
				PAT_DECREMENT: b = (jj == down);
				PAT_CHASE: b = (step_mod == TW'(j));
				PAT_GROW: b = (jj <= s);
				PAT_SHRINK: b = (jj >= s) && (jj < tot);
				PAT_HEART: b = (jj < lim) || ((k >= zero_s) && (k < lim));
				PAT_WAVE: b = (jj < tot) && (({1'b0, jm3} + {1'b0, sm3} == 3'd0) ||
					({1'b0, jm3} + {1'b0, sm3} == 3'd3));
				PAT_RANDOM: b = lfsr_next[j];
				PAT_ALT: b = req.step[0] ? ALT_ODD[j] : ALT_EVEN[j];
				default: b = 1'b0;
			endcase
			st[j] = b;
			jm3 = (jm3 == 2'd2) ? 2'd0 : jm3 + 2'd1;
		end
	end

endmodule

[design/led_bar_pattern_sequencer.sv]
// LED bar pattern sequencer.
// Input stream s_axis: tuser carries the operation, tdata the pin combination
// and the pattern number. Output stream m_axis: one transaction per chip word,
// highest chip first, with tuser set; tlast marks the final transaction of a
// command. Commands that send no frame return one status transaction with
// tuser low. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle (not enforced here).
// Flow: the chip words live in a one-port-write, registered-read RAM. A
// frame is read out chip by chip (read, then load into the output), after
// a write pass over all chips when the words are rewritten first. A decimal
// digit list costs, per digit, one multiply by the reciprocal of ten and
// one update. An animation step adds the step modulo and pattern generation;
// an automatic stop sends a second cleared frame. s_axis_tready is high only
// in the idle state, so one command is handled at a time.
// Reset clears all words (valid bits) and the pattern state and reloads the LFSR seed.
// When m_axis_tready is low the held transaction stays and the block waits.
`include "led_bar_pattern_sequencer_macros.svh"
module led_bar_pattern_sequencer import lbps_pkg::*; #(
	parameter int MAX_CHIPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] pin_combination, [35:32] pattern_id, [39:36] zero
	input  logic [39:0] s_axis_tdata,
	// [2:0] operation
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] chip_index, [18:3] chip_word, [22:19] current_pattern,
	// [23] pattern_complete, [24] last_error, [31:25] zero
	output logic [31:0] m_axis_tdata,
	// [0] frame_sent
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW  = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
	localparam int CNW = $clog2(MAX_CHIPS + 1);
	localparam int TW  = $clog2(16 * MAX_CHIPS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DMUL = 4'd1;
	localparam logic [3:0] ST_DUPD = 4'd2;
	localparam logic [3:0] ST_MOD  = 4'd3;
	localparam logic [3:0] ST_PAT  = 4'd4;
	localparam logic [3:0] ST_WR   = 4'd5;
	localparam logic [3:0] ST_ERD  = 4'd6;
	localparam logic [3:0] ST_ELD  = 4'd7;
	localparam logic [3:0] ST_STAT = 4'd8;

	logic [15:0] speed_q;
	logic [4:0]  pins_q;
	logic [3:0]  chips_q;
	logic [7:0]  maxrep_q;

	logic [3:0]  active_q;
	logic [7:0]  step_q;
	logic [7:0]  rep_q;
	logic        paused_q;
	logic [15:0] ticks_q;
	logic        err_q;
	logic [15:0] lfsr_q;
	logic [MAX_CHIPS-1:0] valid_q;

	logic [3:0]    state_q;
	logic [1:0]    src_q;
	logic [31:0]   pc_q;
	logic [63:0]   prod_q;
	logic [15:0]   vec_q;
	logic [TW-1:0] pin_q;
	logic [TW-1:0] base_q;
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] modr_q;
	logic [2:0]    modi_q;
	logic          auto_q;

	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;
	logic          m_tuser_q;
	logic          m_tlast_q;

	logic [4:0]     pins_eff;
	logic [CNW-1:0] chips_eff;
	logic [TW-1:0]  total;
	logic [CW-1:0]  cnt_top;
	logic           complete;
	logic           s_accept;
	logic           out_free;
	logic [31:0]    pc_in;
	logic [3:0]     pat_in;
	logic [15:0]    rd_word;
	logic [15:0]    wr_word;
	logic [15:0]    st;
	logic [15:0]    lfsr_nxt;
	pat_req_t       preq;
	logic [28:0]    q10;
	logic [3:0]     dig;
	logic [TW:0]    mod_t;
	logic [15:0]    tick_nx;
	logic [8:0]     step_nx;
	logic [7:0]     rep_nx;
	logic [TW:0]    base_end;
	logic [TW-1:0]  pin_off;
	logic           load_en;
	logic           load_frame;
	logic           load_last;

	// Saturate sizes and form the total pin count
	always_comb begin
		pins_eff = pins_q;
		if (pins_q == 5'd0) begin
			pins_eff = 5'd1;
		end else if (pins_q > 5'd16) begin
			pins_eff = 5'd16;
		end
		if (chips_q == 4'd0) begin
			chips_eff = CNW'(1);
		end else if (chips_q > MAX_CHIPS) begin
			chips_eff = CNW'(MAX_CHIPS);
		end else begin
			chips_eff = CNW'(chips_q);
		end
		total = TW'(pins_eff) * TW'(chips_eff);
		cnt_top = CW'(chips_eff - CNW'(1));
	end

	assign complete = (active_q == PAT_NONE) || ((maxrep_q != 8'd0) && (rep_q >= maxrep_q));
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign pc_in = s_axis_tdata[31:0];
	assign pat_in = s_axis_tdata[35:32];

	// Decimal digit split from the registered reciprocal product
	always_comb begin
		q10 = prod_q[63:35];
		dig = 4'(pc_q - ({q10, 3'b000} + {2'b00, q10, 1'b0}));
	end

	// Restoring step modulo, one bit a cycle
	assign mod_t = {modr_q, step_q[modi_q]};

	assign tick_nx = (ticks_q == ALL_ONES) ? ticks_q : ticks_q + 16'd1;
	assign step_nx = {1'b0, step_q} + 9'd1;
	assign rep_nx = rep_q + 8'd1;

	// Pattern generator
	assign preq = '{pattern: active_q, step: step_q, lfsr: lfsr_q};

	lbps_pattern #(.TW(TW)) u_pattern (
		.req       (preq),
		.total     (total),
		.step_mod  (modr_q),
		.st        (st),
		.lfsr_next (lfsr_nxt)
	);

	// Chip word for the writer
	always_comb begin
		base_end = {1'b0, base_q} + (TW + 1)'(pins_eff);
		pin_off = pin_q - base_q;
		case (src_q)
			SRC_ONES: wr_word = ALL_ONES;
			SRC_PIN: wr_word = ((pin_q >= base_q) && ({1'b0, pin_q} < base_end)) ?
				(16'd1 << pin_off[3:0]) : 16'd0;
			SRC_VEC: wr_word = (base_q >= TW'(16)) ? 16'd0 :
				((vec_q >> base_q[3:0]) & low_mask(pins_eff));
			default: wr_word = 16'd0;
		endcase
	end

	lbps_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_CHIPS)) u_words (
		.clk   (clk),
		.we    (state_q == ST_WR),
		.waddr (cnt_q),
		.wdata (wr_word),
		.re    (state_q == ST_ERD),
		.raddr (cnt_q),
		.rdata (rd_word)
	);

	// Output load decisions
	always_comb begin
		load_en = out_free && ((state_q == ST_ELD) || (state_q == ST_STAT));
		load_frame = (state_q == ST_ELD);
		load_last = (state_q == ST_STAT) || ((cnt_q == CW'(0)) && !auto_q);
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd100;
			pins_q <= 5'd8;
			chips_q <= 4'd1;
			maxrep_q <= 8'd0;
			active_q <= PAT_NONE;
			step_q <= 8'd0;
			rep_q <= 8'd0;
			paused_q <= 1'b0;
			ticks_q <= 16'd0;
			err_q <= 1'b0;
			lfsr_q <= LFSR_SEED;
			valid_q <= '0;
			state_q <= ST_IDLE;
			auto_q <= 1'b0;
		end else begin
			// Take register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED: speed_q <= cfg_data;
					REG_PINS: pins_q <= cfg_data[4:0];
					REG_CHIPS: begin
						chips_q <= cfg_data[3:0];
						valid_q <= '0;
					end
					REG_REPEATS: begin
						maxrep_q <= cfg_data[7:0];
						rep_q <= 8'd0;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						base_q <= '0;
						vec_q <= 16'd0;
						case (s_axis_tuser)
							OP_SET_BARS: begin
								if (pat_in > PAT_ALT) begin
									err_q <= 1'b1;
									state_q <= ST_STAT;
								end else if (pat_in != PAT_NONE) begin
									valid_q <= '0;
									active_q <= pat_in;
									step_q <= 8'd0;
									rep_q <= 8'd0;
									ticks_q <= 16'd0;
									cnt_q <= cnt_top;
									state_q <= ST_ERD;
								end else begin
									valid_q <= '0;
									active_q <= PAT_NONE;
									pc_q <= pc_in;
									if (pc_in <= 32'(total)) begin
										pin_q <= TW'(pc_in - 32'd1);
										src_q <= SRC_PIN;
										// Pin zero lights nothing: read out the cleared frame
										cnt_q <= (pc_in == 32'd0) ? cnt_top : '0;
										state_q <= (pc_in == 32'd0) ? ST_ERD : ST_WR;
									end else begin
										state_q <= ST_DMUL;
									end
								end
							end
							OP_CLEAR, OP_STOP: begin
								active_q <= PAT_NONE;
								valid_q <= '0;
								cnt_q <= cnt_top;
								state_q <= ST_ERD;
							end
							OP_SET_ALL: begin
								active_q <= PAT_NONE;
								src_q <= SRC_ONES;
								cnt_q <= '0;
								state_q <= ST_WR;
							end
							OP_PAUSE: begin
								paused_q <= 1'b1;
								state_q <= ST_STAT;
							end
							OP_RESUME: begin
								paused_q <= 1'b0;
								ticks_q <= 16'd0;
								state_q <= ST_STAT;
							end
							OP_TICK: begin
								if ((active_q == PAT_NONE) || paused_q) begin
									state_q <= ST_STAT;
								end else if (tick_nx < speed_q) begin
									ticks_q <= tick_nx;
									state_q <= ST_STAT;
								end else begin
									ticks_q <= 16'd0;
									modr_q <= '0;
									modi_q <= 3'd7;
									state_q <= ST_MOD;
								end
							end
							default: state_q <= ST_STAT;
						endcase
					end
				end
				ST_DMUL: begin
					prod_q <= {32'd0, pc_q} * RECIP10;
					state_q <= ST_DUPD;
				end
				ST_DUPD: begin
					// Mark the digit and drop it from the number
					if ((dig != 4'd0) && (dig <= total)) begin
						vec_q[dig - 4'd1] <= 1'b1;
					end
					pc_q <= {3'b000, q10};
					if (q10 == 29'd0) begin
						src_q <= SRC_VEC;
						cnt_q <= '0;
						state_q <= ST_WR;
					end else begin
						state_q <= ST_DMUL;
					end
				end
				ST_MOD: begin
					modr_q <= (mod_t >= {1'b0, total}) ? TW'(mod_t - {1'b0, total}) :
						TW'(mod_t);
					modi_q <= modi_q - 3'd1;
					if (modi_q == 3'd0) begin
						state_q <= ST_PAT;
					end
				end
				ST_PAT: begin
					// Latch the step word and advance step and repeat counts
					if (active_q == PAT_RANDOM) begin
						lfsr_q <= lfsr_nxt;
					end
					vec_q <= st;
					src_q <= SRC_VEC;
					cnt_q <= '0;
					valid_q <= '0;
					if (step_nx >= 9'(total)) begin
						step_q <= 8'd0;
						rep_q <= rep_nx;
						if ((maxrep_q != 8'd0) && (rep_nx >= maxrep_q)) begin
							active_q <= PAT_NONE;
							auto_q <= 1'b1;
						end
					end else begin
						step_q <= step_nx[7:0];
					end
					state_q <= ST_WR;
				end
				ST_WR: begin
					valid_q[cnt_q] <= 1'b1;
					base_q <= TW'(base_end);
					if (cnt_q == cnt_top) begin
						state_q <= ST_ERD;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					if (out_free) begin
						if (cnt_q == CW'(0)) begin
							if (auto_q) begin
								// Follow the last step with a cleared frame
								auto_q <= 1'b0;
								valid_q <= '0;
								cnt_q <= cnt_top;
								state_q <= ST_ERD;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							cnt_q <= cnt_q - CW'(1);
							state_q <= ST_ERD;
						end
					end
				end
				ST_STAT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_en) begin
			m_tuser_q <= load_frame;
			m_tlast_q <= load_last;
			m_tdata_q <= {7'd0, err_q, complete, active_q,
				(load_frame && valid_q[cnt_q]) ? rd_word : 16'd0,
				load_frame ? 3'(cnt_q) : 3'd0};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;
	assign m_axis_tuser = m_tuser_q;
	assign m_axis_tlast = m_tlast_q;

	`LBPS_ASSERT_NEXT(a_accept_leaves_idle, s_accept, state_q != ST_IDLE, "accept stayed idle")
	`LBPS_ASSERT_SAME(a_last_frame_chip0, m_axis_tvalid && m_axis_tuser && m_axis_tlast,
		m_axis_tdata[2:0] == 3'd0, "last frame word not chip zero")
	`LBPS_ASSERT_SAME(a_status_item, m_axis_tvalid && !m_axis_tuser,
		m_axis_tlast && (m_axis_tdata[18:0] == 19'd0), "malformed status item")
	`LBPS_ASSERT_SAME(a_complete_pattern, m_axis_tvalid && !m_axis_tdata[23],
		m_axis_tdata[22:19] != PAT_NONE, "incomplete with no pattern")

endmodule

[sim/led_bar_pattern_sequencer_tb.sv]
`timescale 1ns / 1ps
module led_bar_pattern_sequencer_tb import lbps_pkg::*; ();

	localparam int MAX_CHIPS = 8;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct packed {
		logic        frame_sent;
		logic [2:0]  chip_index;
		logic [15:0] chip_word;
		logic        last_item;
		logic [3:0]  cur_pattern;
		logic        complete;
		logic        err;
	} led_item_t;

	// Expected-frame tracker with its own copy of the sequencer state
	class led_frame_scoreboard;
		logic [15:0] speed;
		logic [4:0]  pins_reg;
		logic [3:0]  chips_reg;
		logic [7:0]  repeats_max;
		logic [15:0] words[MAX_CHIPS];
		logic [3:0]  pattern;
		logic [7:0]  step;
		logic [7:0]  passes;
		logic        paused;
		logic [15:0] ticks;
		logic        err;
		logic [15:0] lfsr;
		led_item_t   pending[$];
		int          fails;

		function void init();
			speed = 100; pins_reg = 8; chips_reg = 1; repeats_max = 0;
			foreach (words[i]) words[i] = 0;
			pattern = PAT_NONE; step = 0; passes = 0; paused = 0;
			ticks = 0; err = 0; lfsr = LFSR_SEED; fails = 0;
			pending.delete();
		endfunction

		function int pins_eff();
			if (pins_reg < 1) return 1;
			if (pins_reg > 16) return 16;
			return pins_reg;
		endfunction

		function int chips_eff();
			if (chips_reg < 1) return 1;
			if (chips_reg > MAX_CHIPS) return MAX_CHIPS;
			return chips_reg;
		endfunction

		function logic [15:0] one_bit(int n);
			return (n >= 0 && n < 16) ? 16'(1 << n) : 16'h0;
		endfunction

		function logic [15:0] mask_n(int n);
			return n >= 16 ? ALL_ONES : 16'((1 << n) - 1);
		endfunction

		function void clear_words();
			foreach (words[i]) words[i] = 0;
		endfunction

		function void config_write(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_SPEED: speed = val;
				REG_PINS: pins_reg = val[4:0];
				REG_CHIPS: begin
					chips_reg = val[3:0];
					clear_words();
				end
				default: begin
					repeats_max = val[7:0];
					passes = 0;
				end
			endcase
		endfunction

		function void push_frame(ref led_item_t q[$]);
			led_item_t it;
			for (int c = chips_eff() - 1; c >= 0; c--) begin
				it = '{1'b1, 3'(c), words[c], 1'b0, 4'd0, 1'b0, 1'b0};
				q.push_back(it);
			end
		endfunction

		function logic [15:0] pattern_bits(logic [3:0] pat, int s);
			int total, half, lim;
			logic [15:0] st;
			logic        lsb;
			total = pins_eff() * chips_eff();
			st = 0;
			case (pat)
				PAT_INCREMENT, PAT_BOUNCE: st = one_bit(s);
				PAT_DECREMENT: st = one_bit(total - 1 - s);
				PAT_CHASE: st = one_bit(s % total);
				PAT_GROW: for (int i = 0; i <= s && i < 16; i++) st |= one_bit(i);
				PAT_SHRINK: for (int i = s; i < total && i < 16; i++) st |= one_bit(i);
				PAT_HEART: begin
					half = total / 2;
					lim = (s < half) ? s + 1 : total - s + half;
					for (int i = 0; i < lim; i++) st |= one_bit(i) | one_bit(total - 1 - i);
				end
				PAT_RANDOM: begin
					lsb = lfsr[0];
					lfsr = lfsr >> 1;
					if (lsb) lfsr ^= LFSR_TAPS;
					st = lfsr & mask_n(total);
				end
				PAT_WAVE:
					for (int i = 0; i < total && i < 16; i++)
						if ((i + s) % 3 == 0) st |= one_bit(i);
				PAT_ALT: st = (s[0] ? ALT_ODD : ALT_EVEN) & mask_n(total);
				default: st = 0;
			endcase
			return st;
		endfunction

		function void step_animation(ref led_item_t q[$]);
			int pins, chips, sh;
			logic [15:0] st;
			pins = pins_eff();
			chips = chips_eff();
			st = pattern_bits(pattern, step);
			clear_words();
			for (int c = 0; c < chips; c++) begin
				sh = c * pins;
				words[c] = sh >= 16 ? 16'h0 : (st >> sh) & mask_n(pins);
			end
			push_frame(q);
			step = step + 1;
			if (step >= pins * chips) begin
				step = 0;
				passes = passes + 1;
				if (repeats_max > 0 && passes >= repeats_max) begin
					pattern = PAT_NONE;
					clear_words();
					push_frame(q);
				end
			end
		endfunction

		function void light_pin(int d, int pins);
			words[(d - 1) / pins] |= 16'(1 << ((d - 1) % pins));
		endfunction

		function void direct_bars(logic [31:0] pc);
			int pins, total, d;
			pins = pins_eff();
			total = pins * chips_eff();
			if (pc < total + 1) begin
				if (pc > 0) light_pin(pc, pins);
			end else begin
				while (pc > 0) begin
					d = pc % 10;
					if (d > 0 && d <= total) light_pin(d, pins);
					pc = pc / 10;
				end
			end
		endfunction

		// Note one accepted command and queue the items it should cause
		function void note_command(logic [2:0] op, logic [31:0] pc, logic [3:0] pat);
			led_item_t q[$];
			led_item_t it;
			logic done;
			case (op)
				OP_SET_BARS: begin
					if (pat > PAT_ALT) begin
						err = 1;
					end else begin
						clear_words();
						if (pat != PAT_NONE) begin
							pattern = pat; step = 0; passes = 0; ticks = 0;
						end else begin
							pattern = PAT_NONE;
							direct_bars(pc);
						end
						push_frame(q);
					end
				end
				OP_CLEAR, OP_STOP: begin
					pattern = PAT_NONE;
					clear_words();
					push_frame(q);
				end
				OP_SET_ALL: begin
					pattern = PAT_NONE;
					for (int c = 0; c < chips_eff(); c++) words[c] = ALL_ONES;
					push_frame(q);
				end
				OP_PAUSE: paused = 1;
				OP_RESUME: begin
					paused = 0;
					ticks = 0;
				end
				OP_TICK: begin
					if (pattern != PAT_NONE && !paused) begin
						if (ticks != 16'hFFFF) ticks++;
						if (ticks >= speed) begin
							ticks = 0;
							step_animation(q);
						end
					end
				end
				default: ;
			endcase
			if (q.size() == 0) begin
				it = '{1'b0, 3'd0, 16'd0, 1'b0, 4'd0, 1'b0, 1'b0};
				q.push_back(it);
			end
			done = (pattern == PAT_NONE) || (repeats_max > 0 && passes >= repeats_max);
			foreach (q[k]) begin
				q[k].last_item = (k == q.size() - 1);
				q[k].cur_pattern = pattern;
				q[k].complete = done;
				q[k].err = err;
				pending.push_back(q[k]);
			end
		endfunction

		// Compare one received item against the oldest expectation
		function void check_item(led_item_t got);
			led_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item frame=%0b chip=%0d word=%h", $time,
					got.frame_sent, got.chip_index, got.chip_word);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected fs=%0b ch=%0d w=%h l=%0b p=%0d c=%0b e=%0b",
					$time, want.frame_sent, want.chip_index, want.chip_word,
					want.last_item, want.cur_pattern, want.complete, want.err);
				$display("%0t:          actual   fs=%0b ch=%0d w=%h l=%0b p=%0d c=%0b e=%0b",
					$time, got.frame_sent, got.chip_index, got.chip_word,
					got.last_item, got.cur_pattern, got.complete, got.err);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	led_frame_scoreboard sb;
	bit  calm;
	bit  hold_off;
	int  cycle_count;

	led_bar_pattern_sequencer #(.MAX_CHIPS(MAX_CHIPS)) uut (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("led_bar_pattern_sequencer_tb NOT OK");
			$finish;
		end
	end

	// Receive side: random stalls, plus one long hold-off on request
	initial begin
		int burst;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 8);
				m_axis_tready <= 0;
				repeat (burst) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// Check each accepted output transaction
	always @(posedge clk) begin
		led_item_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.frame_sent = m_axis_tuser;
			got.chip_index = m_axis_tdata[2:0];
			got.chip_word = m_axis_tdata[18:3];
			got.last_item = m_axis_tlast;
			got.cur_pattern = m_axis_tdata[22:19];
			got.complete = m_axis_tdata[23];
			got.err = m_axis_tdata[24];
			sb.check_item(got);
		end
	end

	// Offer one command; valid stays up until an idle gap or a drain drops it
	task automatic send_cmd(logic [2:0] op, logic [31:0] pc, logic [3:0] pat);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'd0, pat, pc};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_command(op, pc, pat);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.config_write(idx, val);
		@(posedge clk);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_cmd(OP_TICK, $urandom, 4'($urandom));
	endtask

	// Mostly pattern runs with ticks, some noise commands
	task automatic random_phase(int n);
		int k, sel;
		k = 0;
		while (k < n) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				send_cmd(OP_SET_BARS, $urandom, 4'($urandom_range(1, 10)));
				send_ticks(6);
				k += 7;
			end else if (sel < 6) begin
				send_cmd(OP_SET_BARS, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 140),
					$urandom_range(0, 5) == 0 ? 4'($urandom_range(11, 15)) : PAT_NONE);
				k++;
			end else begin
				send_cmd(3'($urandom_range(0, 7)), $urandom, 4'($urandom));
				k++;
			end
		end
	endtask

	initial begin
		sb = new();
		sb.init();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		cfg_we = 0;
		cfg_index = REG_SPEED;
		cfg_data = 0;
		calm = 0;
		hold_off = 0;
		cycle_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, every operation, direct and digit forms, errors
		send_cmd(OP_SET_BARS, 32'd1, PAT_NONE);
		send_cmd(OP_SET_BARS, 32'd8, PAT_NONE);
		send_cmd(OP_SET_BARS, 32'd0, PAT_NONE);
		send_cmd(OP_SET_BARS, 32'd9, PAT_NONE);
		send_cmd(OP_SET_BARS, 32'hFFFFFFFF, PAT_NONE);
		send_cmd(OP_SET_BARS, 32'd0, 4'd15);
		send_cmd(OP_SET_ALL, 32'd0, PAT_NONE);
		send_cmd(OP_CLEAR, 32'd0, PAT_NONE);
		send_cmd(3'd7, 32'd0, PAT_NONE);
		drain();
		write_reg(REG_SPEED, 16'd0);
		write_reg(REG_REPEATS, 16'd1);
		send_cmd(OP_SET_BARS, 32'd0, PAT_RANDOM);
		send_cmd(OP_PAUSE, 32'd0, PAT_NONE);
		send_cmd(OP_TICK, 32'd0, PAT_NONE);
		send_cmd(OP_RESUME, 32'd0, PAT_NONE);
		send_ticks(9);
		send_cmd(OP_STOP, 32'd0, PAT_NONE);
		drain();

		// Oversized sizes and the widest chain
		write_reg(REG_PINS, 16'd31);
		write_reg(REG_CHIPS, 16'd15);
		send_cmd(OP_SET_BARS, 32'd128, PAT_NONE);
		send_cmd(OP_SET_BARS, 32'd987654321, PAT_NONE);
		send_cmd(OP_SET_ALL, 32'd0, PAT_NONE);

		// Long receiver hold-off while the sender keeps offering
		hold_off = 1;
		random_phase(30);
		drain();

		// Random phases across several settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_SPEED, ph == 0 ? 16'hFFFF : 16'($urandom_range(0, 3)));
			write_reg(REG_PINS, ph == 1 ? 16'd0 : 16'($urandom_range(1, 16)));
			write_reg(REG_CHIPS, ph == 2 ? 16'd0 : 16'($urandom_range(1, 3)));
			write_reg(REG_REPEATS, ph == 3 ? 16'd255 : 16'($urandom_range(0, 2)));
			if (ph == 7) calm = 1;
			random_phase(40);
			drain();
		end

		if (sb.fails == 0 && sb.pending.size() == 0) begin
			$display("led_bar_pattern_sequencer_tb OK");
		end else begin
			$display("led_bar_pattern_sequencer_tb NOT OK");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/lbps_pkg.sv
design/lbps_ram.sv
design/lbps_pattern.sv
design/led_bar_pattern_sequencer.sv
sim/led_bar_pattern_sequencer_tb.sv
